>>> hw/rtl/random_walk_cell_histogram_defines.svh
// Assertion macros for the random walk cell histogram block.
// Taken in by the top level; expects i_clk and i_rst_n in scope.
`ifndef RANDOM_WALK_CELL_HISTOGRAM_DEFINES_SVH
`define RANDOM_WALK_CELL_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RWCH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RWCH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rwch_pkg.sv
// Shared types, constants and the coordinate step function of the random walk histogram.
// No dependencies; imported by every module of the block but the generic RAM.
package rwch_pkg;

    // Default sizes.
    localparam int PARTICLES_DEF = 32;
    localparam int GRID_MAX_DEF  = 32;

    // Fixed-point position: one grid unit is UNITS fraction steps.
    localparam int                 UNITS      = 2000;
    localparam logic signed [15:0] WHOLE_MIN  = -16'sd32768;
    localparam logic signed [15:0] WHOLE_MAX  = 16'sd32767;
    localparam logic [10:0]        FRAC_TOP   = 11'd1999;
    localparam logic [31:0]        COUNT_MAX  = 32'hFFFF_FFFF;

    // Configuration port.
    localparam int         CFG_ADDR_W = 2;
    localparam int         CFG_DATA_W = 11;
    localparam logic [1:0] CFG_GRID_CELLS   = 2'd0;
    localparam logic [1:0] CFG_RADIUS_UNITS = 2'd1;
    localparam logic [1:0] CFG_START_X      = 2'd2;
    localparam logic [1:0] CFG_START_Y      = 2'd3;

    // Stream widths.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic [5:0]  grid_cells;
        logic [10:0] radius_units;
        logic [4:0]  start_x;
        logic [4:0]  start_y;
    } t_cfg;

    // Item classes decided by the front end.
    typedef enum logic [1:0] {
        K_MOVE,
        K_READ,
        K_ZERO
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] particle;
        logic [6:0] step_x;
        logic [6:0] step_y;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] whole;
        logic [10:0]        frac;
    } t_coord;

    // One particle's stored record.
    typedef struct packed {
        logic   placed;
        t_coord x;
        t_coord y;
    } t_part;

    typedef struct packed {
        logic signed [15:0] pos_x_whole;
        logic [10:0]        pos_x_fraction;
        logic signed [15:0] pos_y_whole;
        logic [10:0]        pos_y_fraction;
        logic               captured;
        logic [31:0]        cell_count;
    } t_result;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREAD,
        S_ADV,
        S_MULX,
        S_MULY,
        S_MULR,
        S_CMP,
        S_HREAD,
        S_HWAIT,
        S_EMIT
    } t_state;

    // Moves a coordinate by (2*draw - 99) fraction steps, carries into the
    // whole part and saturates at the ends of the whole range.
    function automatic t_coord f_advance(t_coord c, logic [6:0] draw);
        logic signed [12:0] sum;
        t_coord             n;
        sum = $signed({2'b00, c.frac}) + $signed({5'b00000, draw, 1'b0}) - 13'sd99;
        n   = c;
        if (sum < 13'sd0) begin
            if (c.whole == WHOLE_MIN) begin
                n.whole = WHOLE_MIN;
                n.frac  = '0;
            end else begin
                n.whole = c.whole - 16'sd1;
                n.frac  = 11'(sum + 13'sd2000);
            end
        end else if (sum >= 13'sd2000) begin
            if (c.whole == WHOLE_MAX) begin
                n.whole = WHOLE_MAX;
                n.frac  = FRAC_TOP;
            end else begin
                n.whole = c.whole + 16'sd1;
                n.frac  = 11'(sum - 13'sd2000);
            end
        end else begin
            n.frac = 11'(sum);
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/random_walk_cell_histogram.sv
// Channel   | Dir | Payload (lowest bits first)
// s_axis    | in  | tdata: particle, step_x, step_y, cell_x, cell_y; tuser: action
// m_axis    | out | tdata: pos_x_whole, pos_x_fraction, pos_y_whole, pos_y_fraction,
//           |     |        cell_count; tuser: captured
// cfg       | in  | write of grid_cells, radius_units, start_x or start_y
//
// In the back-end sequencer a move passes particle read, step, three squarings on one shared
// multiplier, compare and histogram update; a read passes histogram read and wait.
// The front queue holds two items, so up to two further input transfers are taken while the
// back end works or while a finished result waits in the output register.
// After reset the particle table and histogram are cleared over max(PARTICLES, GRID_MAX**2)
// addresses (1024 by default) with s_axis tready low; configuration writes are taken throughout.
//
// Top level of the random walk cell histogram; depends on rwch_pkg, rwch_front, rwch_back
// and the assertion macros in random_walk_cell_histogram_defines.svh.
`include "random_walk_cell_histogram_defines.svh"

module random_walk_cell_histogram
    import rwch_pkg::*;
#(
    parameter int PARTICLES = PARTICLES_DEF,
    parameter int GRID_MAX  = GRID_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // particle[4:0], step_x[11:5], step_y[18:12], cell_x[23:19], cell_y[28:24], zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // action[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // pos_x_whole[15:0], pos_x_fraction[26:16], pos_y_whole[42:27],
    // pos_y_fraction[53:43], cell_count[85:54], zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // captured[0]
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    q_valid;
    logic    q_ready;
    t_cmd    q_cmd;
    logic    back_clearing;
    t_result res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_cells   <= 6'd21;
            r_cfg.radius_units <= 11'd1000;
            r_cfg.start_x      <= 5'd10;
            r_cfg.start_y      <= 5'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GRID_CELLS:   r_cfg.grid_cells   <= i_cfg_wdata[5:0];
                CFG_RADIUS_UNITS: r_cfg.radius_units <= i_cfg_wdata;
                CFG_START_X:      r_cfg.start_x      <= i_cfg_wdata[4:0];
                CFG_START_Y:      r_cfg.start_y      <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    rwch_front #(
        .PARTICLES (PARTICLES),
        .GRID_MAX  (GRID_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_data     (i_s_axis_tdata),
        .i_user     (i_s_axis_tuser),
        .o_ready    (o_s_axis_tready),
        .i_clearing (back_clearing),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_ready  (q_ready)
    );

    rwch_back #(
        .PARTICLES (PARTICLES),
        .GRID_MAX  (GRID_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_ready  (q_ready),
        .o_clearing (back_clearing),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res      (res)
    );

    // Pack the result, first field in the lowest bits.
    assign o_m_axis_tdata = {2'b00, res.cell_count, res.pos_y_fraction, res.pos_y_whole,
                             res.pos_x_fraction, res.pos_x_whole};
    assign o_m_axis_tuser = res.captured;

    // No transfer is taken while the memories are being cleared.
    `RWCH_ASSERT_IMP(a_no_accept_in_clear, back_clearing, !o_s_axis_tready, "accept during clear")

    // A captured move always reports a nonzero count.
    `RWCH_ASSERT_IMP(a_capture_count, o_m_axis_tvalid && o_m_axis_tuser, res.cell_count != 32'd0, "captured with zero count")

    // Reported fractions stay below one grid unit.
    `RWCH_ASSERT_IMP(a_frac_range, o_m_axis_tvalid, (int'(res.pos_x_fraction) < UNITS) && (int'(res.pos_y_fraction) < UNITS), "fraction out of range")

    // The sequencer takes one queued item and is busy in the cycle after.
    `RWCH_ASSERT_NXT(a_single_pop, q_valid && q_ready, !q_ready, "back end popped twice in a row")

endmodule

>>> hw/rtl/rwch_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the particle table and the histogram.
module rwch_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rwch_front.sv
// Front end: accepts stream items, classifies them and queues them for the back end.
// Depends on rwch_pkg.
module rwch_front
    import rwch_pkg::*;
#(
    parameter int PARTICLES = PARTICLES_DEF,
    parameter int GRID_MAX  = GRID_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_user,
    output logic                 o_ready,
    input  logic                 i_clearing,
    output logic                 o_q_valid,
    output t_cmd                 o_q_cmd,
    input  logic                 i_q_ready
);

    t_cmd       in_cmd;
    t_cmd       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    // Unpack the transfer and decide what kind of work it needs.
    always_comb begin
        in_cmd.particle = i_data[4:0];
        in_cmd.step_x   = i_data[11:5];
        in_cmd.step_y   = i_data[18:12];
        in_cmd.cell_x   = i_data[23:19];
        in_cmd.cell_y   = i_data[28:24];
        if (i_user) begin
            if ((int'(in_cmd.cell_x) < GRID_MAX) && (int'(in_cmd.cell_y) < GRID_MAX)) begin
                in_cmd.kind = K_READ;
            end else begin
                in_cmd.kind = K_ZERO;
            end
        end else if (int'(in_cmd.particle) < PARTICLES) begin
            in_cmd.kind = K_MOVE;
        end else begin
            in_cmd.kind = K_ZERO;
        end
    end

    assign o_ready   = (r_count != 2'd2) && !i_clearing;
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_cmd   = r_buf[r_rd_ptr];

    // Two-entry queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

>>> hw/rtl/rwch_back.sv
// Back end: sequencer that moves particles, tests capture and updates the histogram.
// Depends on rwch_pkg and rwch_ram.
module rwch_back
    import rwch_pkg::*;
#(
    parameter int PARTICLES = PARTICLES_DEF,
    parameter int GRID_MAX  = GRID_MAX_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_ready,
    output logic    o_clearing,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    localparam int PW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int HW    = $clog2(CELLS);
    localparam int SW    = $clog2(GRID_MAX + 1);
    localparam int CLR_N = (PARTICLES > CELLS) ? PARTICLES : CELLS;
    localparam int CLW   = $clog2(CLR_N);
    localparam int PDW   = $bits(t_part);

    t_state          r_state;
    t_state          n_state;
    logic [CLW-1:0]  r_clr_idx;
    t_cmd            r_cmd;
    t_coord          r_px;
    t_coord          r_py;
    logic [22:0]     r_acc;
    logic [21:0]     r_rr;
    logic            r_in_grid;
    t_result         r_res;
    t_result         r_out;
    logic            r_out_valid;

    logic            part_we;
    logic [PW-1:0]   part_waddr;
    t_part           part_wdata;
    logic            part_re;
    logic [PW-1:0]   part_raddr;
    logic [PDW-1:0]  part_rdata;
    t_part           part_rec;
    logic            hit_we;
    logic [HW-1:0]   hit_waddr;
    logic [31:0]     hit_wdata;
    logic            hit_re;
    logic [HW-1:0]   hit_raddr;
    logic [31:0]     hit_rdata;

    t_coord          base_x;
    t_coord          base_y;
    t_coord          n_px;
    t_coord          n_py;
    logic [SW-1:0]   side;
    logic            in_grid;
    logic [HW-1:0]   pos_idx;
    logic [HW-1:0]   read_idx;
    logic [10:0]     mul_a;
    logic [21:0]     product;
    logic            capture;
    logic [31:0]     count_inc;
    logic            out_load;

    // Particle table: placed flag and position of every particle.
    rwch_ram #(
        .WIDTH (PDW),
        .DEPTH (PARTICLES)
    ) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (part_we),
        .i_waddr (part_waddr),
        .i_wdata (part_wdata),
        .i_re    (part_re),
        .i_raddr (part_raddr),
        .o_rdata (part_rdata)
    );

    // Shared histogram, cell (x, y) at y * GRID_MAX + x.
    rwch_ram #(
        .WIDTH (32),
        .DEPTH (CELLS)
    ) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (hit_we),
        .i_waddr (hit_waddr),
        .i_wdata (hit_wdata),
        .i_re    (hit_re),
        .i_raddr (hit_raddr),
        .o_rdata (hit_rdata)
    );

    // Position step: a particle that was never placed starts at the start point.
    always_comb begin
        part_rec     = t_part'(part_rdata);
        base_x.whole = $signed({11'b0, i_cfg.start_x});
        base_x.frac  = '0;
        base_y.whole = $signed({11'b0, i_cfg.start_y});
        base_y.frac  = '0;
        if (part_rec.placed) begin
            base_x = part_rec.x;
            base_y = part_rec.y;
        end
        n_px = f_advance(base_x, r_cmd.step_x);
        n_py = f_advance(base_y, r_cmd.step_y);
    end

    // Grid test, cell addresses, shared squarer and saturating increment.
    always_comb begin
        if (int'(i_cfg.grid_cells) > GRID_MAX) begin
            side = SW'(GRID_MAX);
        end else begin
            side = SW'(i_cfg.grid_cells);
        end
        in_grid = !r_px.whole[15] && !r_py.whole[15]
                  && ($unsigned(r_px.whole) < 16'(side))
                  && ($unsigned(r_py.whole) < 16'(side));
        pos_idx   = HW'(HW'($unsigned(r_py.whole)) * GRID_MAX + HW'($unsigned(r_px.whole)));
        read_idx  = HW'(HW'(r_cmd.cell_y) * GRID_MAX + HW'(r_cmd.cell_x));
        product   = {11'b0, mul_a} * {11'b0, mul_a};
        capture   = r_in_grid && (r_acc <= {1'b0, r_rr});
        count_inc = (hit_rdata == COUNT_MAX) ? hit_rdata : hit_rdata + 32'd1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == CLW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.kind)
                        K_MOVE:  n_state = S_PREAD;
                        K_READ:  n_state = S_HREAD;
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_PREAD: n_state = S_ADV;
            S_ADV:   n_state = S_MULX;
            S_MULX:  n_state = S_MULY;
            S_MULY:  n_state = S_MULR;
            S_MULR:  n_state = S_CMP;
            S_CMP:   n_state = S_EMIT;
            S_HREAD: n_state = S_HWAIT;
            S_HWAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Per-state controls for the memories, the queue and the output register.
    always_comb begin
        part_we    = 1'b0;
        part_waddr = PW'(r_cmd.particle);
        part_wdata = '{placed: 1'b1, x: n_px, y: n_py};
        part_re    = 1'b0;
        part_raddr = PW'(r_cmd.particle);
        hit_we     = 1'b0;
        hit_waddr  = pos_idx;
        hit_wdata  = count_inc;
        hit_re     = 1'b0;
        hit_raddr  = pos_idx;
        mul_a      = i_cfg.radius_units;
        o_q_ready  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                part_we    = int'(r_clr_idx) < PARTICLES;
                part_waddr = PW'(r_clr_idx);
                part_wdata = '0;
                hit_we     = int'(r_clr_idx) < CELLS;
                hit_waddr  = HW'(r_clr_idx);
                hit_wdata  = '0;
            end
            S_IDLE:  o_q_ready = 1'b1;
            S_PREAD: part_re = 1'b1;
            S_ADV:   part_we = 1'b1;
            S_MULX: begin
                hit_re = 1'b1;
                mul_a  = r_px.frac;
            end
            S_MULY:  mul_a = r_py.frac;
            S_CMP:   hit_we = capture;
            S_HREAD: begin
                hit_re    = 1'b1;
                hit_raddr = read_idx;
            end
            S_EMIT:  out_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + CLW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_cmd <= i_q_cmd;
                    r_res <= '0;
                end
            end
            S_ADV: begin
                r_px <= n_px;
                r_py <= n_py;
            end
            S_MULX: begin
                r_acc     <= {1'b0, product};
                r_in_grid <= in_grid;
            end
            S_MULY: r_acc <= r_acc + {1'b0, product};
            S_MULR: r_rr <= product;
            S_CMP: begin
                r_res.pos_x_whole    <= r_px.whole;
                r_res.pos_x_fraction <= r_px.frac;
                r_res.pos_y_whole    <= r_py.whole;
                r_res.pos_y_fraction <= r_py.frac;
                r_res.captured       <= capture;
                r_res.cell_count     <= capture ? count_inc : 32'd0;
            end
            S_HWAIT: r_res.cell_count <= hit_rdata;
            default: ;
        endcase
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

endmodule
